// ===== rtl/keyed_value_table_small_top_defines.svh =====
`ifndef KEYED_VALUE_TABLE_SMALL_TOP_DEFINES_SVH
`define KEYED_VALUE_TABLE_SMALL_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KVTS_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KVTS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kvts_pkg.sv =====
package kvts_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 4;
  localparam int ENTRIES_DEF  = 10;
  localparam int KEY_BITS_DEF = 32;

  // request codes
  localparam logic [1:0] FN_SET    = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_DELETE = 2'd2;
  localparam logic [1:0] FN_FLAG   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             flag_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
    logic             update_flag;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       scan;
    logic       wr_hit;
    logic       append;
    logic       shift;
    logic       del_end;
    logic       set_flag;
    logic       load_flag;
    logic       take_val;
    logic       st_we;
    logic [1:0] st_code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       hit;
    logic       miss;
    logic       pend;
    logic       full;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== rtl/kvts_ctrl.sv =====
module kvts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output kvts_pkg::dp_cmd_t cmd,
  input  kvts_pkg::dp_sts_t sts
);
  import kvts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN0 = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN0;
        end
      end
      S_SCAN0: begin
        if (sts.func == FN_FLAG) begin
          cmd.load_flag = 1'b1;
          cmd.st_we     = 1'b1;
          cmd.st_code   = ST_DONE;
          state_nxt     = S_RESP;
        end else begin
          cmd.scan  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_DONE;
          unique case (sts.func)
            FN_SET: begin
              cmd.wr_hit   = 1'b1;
              cmd.set_flag = 1'b1;
              state_nxt    = S_RESP;
            end
            FN_LOOKUP: begin
              cmd.take_val = 1'b1;
              state_nxt    = S_RESP;
            end
            FN_DELETE: begin
              state_nxt = S_SHIFT;
            end
            FN_FLAG: begin
              state_nxt = S_RESP;
            end
          endcase
        end else if (sts.miss) begin
          cmd.st_we = 1'b1;
          state_nxt = S_RESP;
          if (sts.func == FN_SET) begin
            if (sts.full) begin
              cmd.st_code = ST_FULL;
            end else begin
              cmd.append   = 1'b1;
              cmd.set_flag = 1'b1;
              cmd.st_code  = ST_DONE;
            end
          end else begin
            cmd.st_code = ST_ABSENT;
          end
        end
      end
      S_SHIFT: begin
        if (sts.pend) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.del_end  = 1'b1;
          cmd.set_flag = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/kvts_dp.sv =====
module kvts_dp #(
  parameter int ENTRIES  = kvts_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = kvts_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kvts_pkg::in_item_t  in_item,
  input  kvts_pkg::dp_cmd_t   cmd,
  output kvts_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output kvts_pkg::out_item_t out_item
);
  import kvts_pkg::*;

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES + 2);

  logic [KW-1:0]    key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];

  logic [1:0]       func_r;
  logic [KW-1:0]    key_r;
  logic [VAL_W-1:0] val_r;
  logic             flag_in_r;

  logic [IW-1:0]    idx_r;
  logic [AW-1:0]    rd_idx_r;
  logic             pend_r;
  logic [KW-1:0]    rd_key_r;
  logic [VAL_W-1:0] rd_val_r;

  logic [CW-1:0]    fill_r;
  logic             flag_r;
  logic [1:0]       st_r;
  logic [VAL_W-1:0] rdval_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic             scan_go;
  logic             key_we;
  logic             val_we;
  logic [AW-1:0]    wr_addr;
  logic [KW-1:0]    wr_key;
  logic [VAL_W-1:0] wr_val;

  assign scan_go = cmd.scan | cmd.shift;
  assign key_we  = cmd.append | cmd.shift;
  assign val_we  = cmd.wr_hit | cmd.append | cmd.shift;

  // write port select: move-up, append at the tail, or overwrite at the hit
  always_comb begin
    priority if (cmd.shift) begin
      wr_addr = rd_idx_r - AW'(1);
      wr_key  = rd_key_r;
      wr_val  = rd_val_r;
    end else if (cmd.append) begin
      wr_addr = fill_r[AW-1:0];
      wr_key  = key_r;
      wr_val  = val_r;
    end else begin
      wr_addr = rd_idx_r;
      wr_key  = key_r;
      wr_val  = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (scan_go) begin
      rd_key_r <= key_mem[idx_r[AW-1:0]];
      rd_val_r <= val_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r    <= in_item.func;
      key_r     <= in_item.key[KW-1:0];
      val_r     <= in_item.value;
      flag_in_r <= in_item.flag_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      fill_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else if (scan_go) begin
        idx_r    <= idx_r + IW'(1);
        rd_idx_r <= idx_r[AW-1:0];
        pend_r   <= (idx_r < IW'(fill_r));
      end
      if (cmd.append) begin
        fill_r <= fill_r + CW'(1);
      end else if (cmd.del_end) begin
        fill_r <= fill_r - CW'(1);
      end
      if (cmd.set_flag) begin
        flag_r <= 1'b1;
      end else if (cmd.load_flag) begin
        flag_r <= flag_in_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rdval_r <= '0;
    end else if (cmd.take_val) begin
      rdval_r <= rd_val_r;
    end
    if (cmd.st_we) begin
      st_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_r.status      <= st_r;
      out_r.read_value  <= rdval_r;
      out_r.entry_count <= CNT_W'(fill_r);
      out_r.update_flag <= flag_r;
    end
  end

  assign sts.func     = func_r;
  assign sts.pend     = pend_r;
  assign sts.hit      = pend_r && (rd_key_r == key_r);
  assign sts.miss     = !pend_r;
  assign sts.full     = (fill_r == CW'(ENTRIES));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/keyed_value_table_small_top.sv =====
// flow: a flag write goes straight to its result; set, lookup and delete scan the table,
// one entry per cycle on the single memory read port, and a delete then does the move-up
// throughput: one item at a time, next item taken in the cycle after its result is loaded
// reset: clears fill count, update flag, output valid and control; table contents stay uncleared
`include "keyed_value_table_small_top_defines.svh"

module keyed_value_table_small_top #(
  parameter int ENTRIES  = kvts_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = kvts_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kvts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output kvts_pkg::out_item_t out_item
);
  import kvts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  kvts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  kvts_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `KVTS_CHECK_NOW(a_append_room, cmd.append, !sts.full, "append into a full table")
  `KVTS_CHECK_NOW(a_shift_pend, cmd.shift, sts.pend, "move-up without a pending read")
  `KVTS_CHECK_NOW(a_load_free, cmd.out_load, sts.out_free, "result loaded over a held item")
  `KVTS_CHECK_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule
